// ===== hdl/psrlb_pkg.sv =====
// Package: shared constants, types and command/status structs for the rate limit blocker.
`timescale 1ns / 1ps
`default_nettype none
package psrlb_pkg;
   localparam int POLICIES = 4;
   localparam int SOURCES_PER_POLICY = 8;
   localparam int LOCK_SLOTS = 16;
   localparam int POL_W = (POLICIES > 1) ? $clog2(POLICIES) : 1;
   localparam int SRC_W = (SOURCES_PER_POLICY > 1) ? $clog2(SOURCES_PER_POLICY) : 1;
   localparam int FILL_W = $clog2(SOURCES_PER_POLICY + 1);
   localparam int LOCK_W = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [1:0] ACT_PACKET = 2'd0;
   localparam logic [1:0] ACT_TICK   = 2'd1;
   localparam logic [1:0] ACT_POLICY = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_INTERVAL = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOCK     = 1'd1;

   localparam logic EVT_BLOCK   = 1'b0;
   localparam logic EVT_UNBLOCK = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [1:0]  policy_index;
      logic [31:0] new_policy_ip;
      logic [15:0] new_policy_threshold;
      logic [15:0] new_policy_id;
      logic        policy_enable;
   } req_type;

   typedef struct packed {
      logic        event_res;
      logic [31:0] blocked_ip;
      logic [31:0] victim_ip;
      logic [15:0] event_policy_id;
      logic [15:0] packet_count;
      logic        last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic              do_packet;   // count current request
      logic              do_policy;   // write policy entry
      logic              do_tick;     // advance seconds, evaluate interval close
      logic              src_load;    // register source entry at scan pointer
      logic              blk_eval;    // evaluate loaded source entry
      logic              close_ivl;   // clear fills, restart interval
      logic              lck_eval;    // evaluate lock slot at scan pointer
      logic [POL_W-1:0]  pol;
      logic [SRC_W-1:0]  src;
      logic [LOCK_W-1:0] slot;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic             ivl_closed;
      logic [POLICIES-1:0] pol_active;
      logic [FILL_W-1:0] fill_sel;    // fill of policy cmd.pol
      logic             blk_hit;      // blk_eval produced event
      logic             lck_hit;      // lck_eval produced event
   } sts_type;
endpackage
`default_nettype wire

// ===== hdl/psrlb_if.sv =====
// Interfaces: valid/ready channels for requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface psrlb_req_if import psrlb_pkg::*; ;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface psrlb_rsp_if import psrlb_pkg::*; ;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/psrlb_datapath.sv =====
// Datapath: policy, source and lock tables, seconds counter and event formation.
`timescale 1ns / 1ps
`default_nettype none
module psrlb_datapath import psrlb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire req_type     req,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output rsp_type          evt
);
   logic [7:0]  ivl_ff, lock_sec_ff;
   logic [31:0] pol_dst_ff   [POLICIES];
   logic [15:0] pol_lim_ff   [POLICIES];
   logic [15:0] pol_id_ff    [POLICIES];
   logic [POLICIES-1:0] pol_act_ff;
   logic [FILL_W-1:0] fill_ff [POLICIES];
   logic [31:0] saddr_ff [POLICIES][SOURCES_PER_POLICY];
   logic [15:0] scnt_ff  [POLICIES][SOURCES_PER_POLICY];
   logic [31:0] laddr_ff [LOCK_SLOTS];
   logic [31:0] lstamp_ff[LOCK_SLOTS];
   logic [LOCK_SLOTS-1:0] lused_ff;
   logic [31:0] sec_ff, istart_ff;
   logic        closed_ff;
   // loaded source entry and bound product
   logic [31:0] cur_addr_ff;
   logic [15:0] cur_cnt_ff;
   logic [24:0] bound_ff;
   rsp_type     evt_ff;

   logic [7:0]  ivl_eff;
   logic [31:0] sec_in;
   logic [LOCK_W-1:0] free_slot;
   logic        free_any;

   assign ivl_eff = (ivl_ff == 8'd0) ? 8'd1 : ivl_ff;
   assign sec_in  = sec_ff + 32'd1;

   // lowest free lock slot
   always_comb begin
      free_slot = '0;
      free_any  = 1'b0;
      for (int g = LOCK_SLOTS - 1; g >= 0; g--) begin
         if (!lused_ff[g]) begin
            free_slot = LOCK_W'(g);
            free_any  = 1'b1;
         end
      end
   end

   logic blk_hit, lck_hit;
   assign blk_hit = {9'd0, cur_cnt_ff} >= bound_ff;
   assign lck_hit = lused_ff[cmd.slot] &&
                    ((sec_ff - lstamp_ff[cmd.slot]) >= {24'd0, lock_sec_ff});

   always_comb begin
      sts.ivl_closed = closed_ff;
      sts.pol_active = pol_act_ff;
      sts.fill_sel   = fill_ff[cmd.pol];
      sts.blk_hit    = blk_hit;
      sts.lck_hit    = lck_hit;
   end
   assign evt = evt_ff;

   // control state of tables and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ivl_ff      <= 8'd1;
         lock_sec_ff <= 8'd5;
         pol_act_ff  <= '0;
         lused_ff    <= '0;
         sec_ff      <= '0;
         istart_ff   <= '0;
         closed_ff   <= 1'b0;
         for (int p = 0; p < POLICIES; p++) begin
            fill_ff[p]    <= '0;
            pol_dst_ff[p] <= '0;
            pol_lim_ff[p] <= '0;
            pol_id_ff[p]  <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_INTERVAL: ivl_ff <= csr_wdata;
               CSR_LOCK:     lock_sec_ff <= csr_wdata;
               default: ;
            endcase
         end
         // policy write
         if (cmd.do_policy && ({30'd0, req.policy_index} < POLICIES)) begin
            pol_dst_ff[POL_W'(req.policy_index)] <= req.new_policy_ip;
            pol_lim_ff[POL_W'(req.policy_index)] <= req.new_policy_threshold;
            pol_id_ff[POL_W'(req.policy_index)]  <= req.new_policy_id;
            pol_act_ff[POL_W'(req.policy_index)] <= req.policy_enable;
            fill_ff[POL_W'(req.policy_index)]    <= '0;
         end
         // packet: parallel compare per policy
         if (cmd.do_packet) begin
            for (int p = 0; p < POLICIES; p++) begin
               if (pol_act_ff[p] && pol_dst_ff[p] == req.dst_ip) begin
                  logic found;
                  found = 1'b0;
                  for (int j = 0; j < SOURCES_PER_POLICY; j++) begin
                     if ({1'b0, FILL_W'(j)} < {1'b0, fill_ff[p]} &&
                         saddr_ff[p][j] == req.src_ip) begin
                        found = 1'b1;
                        if (scnt_ff[p][j] != 16'hFFFF)
                           scnt_ff[p][j] <= scnt_ff[p][j] + 16'd1;
                     end
                  end
                  if (!found && ({1'b0, fill_ff[p]} < (FILL_W+1)'(SOURCES_PER_POLICY))) begin
                     saddr_ff[p][SRC_W'(fill_ff[p])] <= req.src_ip;
                     scnt_ff[p][SRC_W'(fill_ff[p])]  <= 16'd1;
                     fill_ff[p] <= fill_ff[p] + FILL_W'(1);
                  end
               end
            end
         end
         // tick
         if (cmd.do_tick) begin
            sec_ff    <= sec_in;
            closed_ff <= (sec_in - istart_ff) >= {24'd0, ivl_eff};
         end
         // block evaluation: take lowest free lock slot
         if (cmd.blk_eval && blk_hit && free_any) begin
            lused_ff[free_slot]  <= 1'b1;
            laddr_ff[free_slot]  <= cur_addr_ff;
            lstamp_ff[free_slot] <= sec_ff;
         end
         if (cmd.close_ivl) begin
            for (int p = 0; p < POLICIES; p++) fill_ff[p] <= '0;
            istart_ff <= sec_ff;
         end
         if (cmd.lck_eval && lck_hit)
            lused_ff[cmd.slot] <= 1'b0;
      end
   end

   // source load and event payload
   always_ff @(posedge clock) begin
      if (cmd.src_load) begin
         cur_addr_ff <= saddr_ff[cmd.pol][cmd.src];
         cur_cnt_ff  <= scnt_ff[cmd.pol][cmd.src];
         bound_ff    <= ({9'd0, pol_lim_ff[cmd.pol]} + 25'd1) * {17'd0, ivl_eff};
      end
      if (cmd.blk_eval) begin
         evt_ff.event_res       <= EVT_BLOCK;
         evt_ff.blocked_ip      <= cur_addr_ff;
         evt_ff.victim_ip       <= pol_dst_ff[cmd.pol];
         evt_ff.event_policy_id <= pol_id_ff[cmd.pol];
         evt_ff.packet_count    <= cur_cnt_ff;
         evt_ff.last            <= 1'b0;
      end else if (cmd.lck_eval) begin
         evt_ff.event_res       <= EVT_UNBLOCK;
         evt_ff.blocked_ip      <= laddr_ff[cmd.slot];
         evt_ff.victim_ip       <= '0;
         evt_ff.event_policy_id <= '0;
         evt_ff.packet_count    <= '0;
         evt_ff.last            <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/psrlb_ctrl.sv =====
// Controller: request sequencing, tick scans and one-deep event hold for last marking.
`timescale 1ns / 1ps
`default_nettype none
module psrlb_ctrl import psrlb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic [1:0] req_action,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic         rsp_last,
   input  wire sts_type sts,
   input  wire rsp_type evt,
   output cmd_type      cmd,
   output rsp_type      hold
);
   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_LOAD, S_EVAL, S_CAPT, S_LOCK, S_LCAPT, S_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic [POL_W-1:0]  pol_ff, pol_in;
   logic [FILL_W-1:0] src_ff, src_in;
   logic [LOCK_W:0]   slot_ff, slot_in;
   // held event awaiting next to decide last; output register
   logic     have_ff, have_in;
   rsp_type  hold_ff, hold_in;
   logic     out_v_ff, out_v_in, out_last_ff, out_last_in;
   rsp_type  out_ff, out_in;
   logic     hit_ff, hit_in;

   logic out_free;
   assign out_free = !out_v_ff || rsp_ready;
   assign rsp_valid = out_v_ff;
   assign rsp_last  = out_last_ff;
   assign hold      = out_ff;

   always_comb begin
      state_in = state_ff; pol_in = pol_ff; src_in = src_ff; slot_in = slot_ff;
      have_in = have_ff; hold_in = hold_ff; hit_in = hit_ff;
      out_v_in = out_v_ff && !rsp_ready; out_in = out_ff; out_last_in = out_last_ff;
      cmd = '0;
      cmd.pol = pol_ff; cmd.src = SRC_W'(src_ff); cmd.slot = LOCK_W'(slot_ff);
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_action)
                  ACT_PACKET: cmd.do_packet = 1'b1;
                  ACT_POLICY: cmd.do_policy = 1'b1;
                  ACT_TICK: begin
                     cmd.do_tick = 1'b1;
                     pol_in = '0; src_in = '0; slot_in = '0;
                     state_in = S_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: state_in = sts.ivl_closed ? S_LOAD : S_LOCK;
         // block scan over policies and their filled entries
         S_LOAD: begin
            if (sts.pol_active[pol_ff] && src_ff < sts.fill_sel) begin
               cmd.src_load = 1'b1;
               state_in = S_EVAL;
            end else begin
               src_in = '0;
               if ({1'b0, pol_ff} == (POL_W+1)'(POLICIES - 1)) begin
                  cmd.close_ivl = 1'b1;
                  state_in = S_LOCK;
               end else pol_in = pol_ff + POL_W'(1);
            end
         end
         S_EVAL: begin
            // evaluate only when an event can be parked
            if (!have_ff || out_free) begin
               cmd.blk_eval = 1'b1;
               hit_in = sts.blk_hit;
               state_in = S_CAPT;
            end
         end
         S_CAPT: begin
            if (hit_ff) begin
               if (have_ff) begin
                  out_v_in = 1'b1; out_in = hold_ff; out_last_in = 1'b0;
               end
               have_in = 1'b1; hold_in = evt;
            end
            src_in = src_ff + FILL_W'(1);
            state_in = S_LOAD;
         end
         S_LOCK: begin
            if (slot_ff == (LOCK_W+1)'(LOCK_SLOTS)) begin
               state_in = S_FLUSH;
            end else if (!have_ff || out_free) begin
               cmd.lck_eval = 1'b1;
               hit_in = sts.lck_hit;
               state_in = S_LCAPT;
            end
         end
         S_LCAPT: begin
            if (hit_ff) begin
               if (have_ff) begin
                  out_v_in = 1'b1; out_in = hold_ff; out_last_in = 1'b0;
               end
               have_in = 1'b1; hold_in = evt;
            end
            slot_in = slot_ff + (LOCK_W+1)'(1);
            state_in = S_LOCK;
         end
         S_FLUSH: begin
            if (!have_ff) state_in = S_IDLE;
            else if (out_free) begin
               out_v_in = 1'b1; out_in = hold_ff; out_last_in = 1'b1;
               have_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; pol_ff <= '0; src_ff <= '0; slot_ff <= '0;
         have_ff <= 1'b0; out_v_ff <= 1'b0; hit_ff <= 1'b0; out_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pol_ff <= pol_in; src_ff <= src_in; slot_ff <= slot_in;
         have_ff <= have_in; out_v_ff <= out_v_in; hit_ff <= hit_in;
         out_last_ff <= out_last_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end
endmodule
`default_nettype wire

// ===== hdl/per_source_rate_limit_blocker_core.sv =====
// Top level: per-source packet rate limiter with timed block list.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | action, addresses, policy write fields
//  rsp     | out | rsp_valid/ready    | block/unblock event, last marker
//  csr     | in  | csr_we             | csr_addr, csr_wdata (no read-back)
//
// Packets and policy writes update the tables directly from idle; the request side accepts one each cycle in idle.
// A tick checks the interval close, then scans the lock table slot by slot; when the interval
// closes it first scans the filled source entries of each active policy, one entry at a time.
// Reset is synchronous, active high; no clearing pass is needed.
// A stalled response channel holds the scan before the next event is produced.
`timescale 1ns / 1ps
`default_nettype none
module per_source_rate_limit_blocker_core import psrlb_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   psrlb_req_if.sink   req,
   psrlb_rsp_if.source rsp,
   input  wire logic csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   rsp_type evt, hold;
   logic    out_last;

   psrlb_datapath u_dp (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req(req.payload), .cmd, .sts, .evt
   );

   psrlb_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_action(req.payload.action), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(out_last),
      .sts, .evt, .cmd, .hold
   );

   always_comb begin
      rsp.payload      = hold;
      rsp.payload.last = out_last;
   end
endmodule
`default_nettype wire

// ===== hdl/psrlb_checker.sv =====
// Checker: port-level properties of the rate limit blocker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module psrlb_checker import psrlb_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic [1:0] req_action,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire rsp_type rsp_payload
);
   // a response is stable while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp changed under stall");
   // unblock events carry zero victim address and packet count
   a_unblock_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_res == EVT_UNBLOCK |->
      rsp_payload.victim_ip == '0 && rsp_payload.packet_count == '0)
      else $error("unblock with policy data");
   // a block event has nonzero count
   a_block_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_res == EVT_BLOCK |-> rsp_payload.packet_count != '0)
      else $error("block with zero count");
   // a tick takes the block out of idle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_TICK |=> !req_ready)
      else $error("ready right after tick");
endmodule

bind per_source_rate_limit_blocker_core psrlb_checker u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready), .req_action(req.payload.action),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
`default_nettype wire
